// ===== sv/fixed_frame_parameter_command_parser_top_macros.svh =====
// Assertion macros for the command parser checker.
// Used by ffpcp_checker.sv only.
`ifndef FIXED_FRAME_PARAMETER_COMMAND_PARSER_TOP_MACROS_SVH
`define FIXED_FRAME_PARAMETER_COMMAND_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FFPCP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ffpcp: assertion failed");

// next-cycle implication, disabled in reset
`define FFPCP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ffpcp: assertion failed");

`endif

// ===== sv/ffpcp_pkg.sv =====
// Shared types, constants and decode functions for the command parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ffpcp_pkg;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 4;
	localparam int ACC_W   = 34;
	localparam int WGT_W   = 24;
	localparam int VAL_W   = 25;
	localparam int MAG_W   = 24;
	localparam int SET_W   = 3;
	localparam int CODE_W  = 3;

	localparam logic [BYTE_W-1:0] CHR_START = 8'h53;
	localparam logic [BYTE_W-1:0] CHR_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CHR_END   = 8'h45;
	localparam logic [BYTE_W-1:0] CHR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHR_KP    = 8'h70;
	localparam logic [BYTE_W-1:0] CHR_KI    = 8'h69;
	localparam logic [BYTE_W-1:0] CHR_KD    = 8'h64;
	localparam logic [BYTE_W-1:0] CHR_SETPT = 8'h74;
	localparam logic [BYTE_W-1:0] CHR_LED   = 8'h4C;
	localparam logic [BYTE_W-1:0] CHR_SETID = 8'h67;

	localparam logic [POS_W-1:0] POS_START = 4'd0;
	localparam logic [POS_W-1:0] POS_CMD   = 4'd1;
	localparam logic [POS_W-1:0] POS_SIGN  = 4'd2;
	localparam logic [POS_W-1:0] POS_DOT   = 4'd7;
	localparam logic [POS_W-1:0] POS_LAST  = 4'd12;

	localparam logic [BYTE_W-1:0] SET_MAX = 8'd7;

	localparam logic signed [ACC_W:0] VAL_LIMIT_WIDE = 35'sd10000000;
	localparam logic signed [VAL_W-1:0] VAL_LIMIT    = 25'sd10000000;

	// trunc(x / 10000) = ((x >> 4) * RECIP) >> RECIP_SHIFT, exact for x < 2^24
	localparam int DIV_SHIFT   = 4;
	localparam int DIV_W       = MAG_W - DIV_SHIFT;
	localparam int RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP = 21'd1717987;
	localparam int RECIP_SHIFT = 30;
	localparam int QUOT_W      = 10;
	localparam int UNIT_W      = 14;
	localparam logic [UNIT_W-1:0] UNIT_ONE = 14'd10000;

	typedef enum logic [1:0] {
		SIGN_NONE  = 2'd0,
		SIGN_PLUS  = 2'd1,
		SIGN_MINUS = 2'd2
	} sign_t;

	typedef enum logic [CODE_W-1:0] {
		FIELD_KP     = 3'd0,
		FIELD_KI     = 3'd1,
		FIELD_KD     = 3'd2,
		FIELD_SETPT  = 3'd3,
		FIELD_LED    = 3'd4,
		FIELD_SET_ID = 3'd5
	} field_t;

	typedef struct packed {
		logic   known;
		field_t code;
	} cmd_t;

	typedef struct packed {
		logic [SET_W-1:0]        set;
		field_t                  code;
		logic                    set_id;
		logic signed [VAL_W-1:0] value;
	} result_t;

	function automatic logic [WGT_W-1:0] digit_weight(input logic [POS_W-1:0] pos);
		logic [WGT_W-1:0] w;
		case (pos)
			4'd3:    w = 24'd10000000;
			4'd4:    w = 24'd1000000;
			4'd5:    w = 24'd100000;
			4'd6:    w = 24'd10000;
			4'd8:    w = 24'd1000;
			4'd9:    w = 24'd100;
			4'd10:   w = 24'd10;
			4'd11:   w = 24'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic cmd_t letter_decode(input logic [BYTE_W-1:0] c);
		cmd_t r;
		r.known = 1'b1;
		case (c)
			CHR_KP:    r.code = FIELD_KP;
			CHR_KI:    r.code = FIELD_KI;
			CHR_KD:    r.code = FIELD_KD;
			CHR_SETPT: r.code = FIELD_SETPT;
			CHR_LED:   r.code = FIELD_LED;
			CHR_SETID: r.code = FIELD_SET_ID;
			default: begin
				r.known = 1'b0;
				r.code  = FIELD_KP;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== sv/ffpcp_frame.sv =====
// Frame state of the command parser: position, accumulator, sign, letter, markers.
// Checks and clamps on the closing byte. Depends on ffpcp_pkg.
`timescale 1ns / 1ps

module ffpcp_frame (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [ffpcp_pkg::BYTE_W-1:0]  byte_in,
	input  logic [ffpcp_pkg::BYTE_W-1:0]  active_set,
	output logic                          hit,
	output ffpcp_pkg::result_t            res
);

	logic [ffpcp_pkg::POS_W-1:0]        pos_q;
	logic signed [ffpcp_pkg::ACC_W-1:0] acc_q;
	ffpcp_pkg::sign_t                   sign_q;
	logic [ffpcp_pkg::BYTE_W-1:0]       letter_q;
	logic                               mk_q;

	logic                                 last;
	logic signed [ffpcp_pkg::BYTE_W:0]    diff;
	logic signed [ffpcp_pkg::WGT_W:0]     wgt;
	logic signed [ffpcp_pkg::ACC_W-1:0]   prod;
	logic signed [ffpcp_pkg::ACC_W:0]     sval;
	logic signed [ffpcp_pkg::VAL_W-1:0]   clamped;
	ffpcp_pkg::cmd_t                      cmd;
	ffpcp_pkg::sign_t                     sign_new;

	assign last = (pos_q >= ffpcp_pkg::POS_LAST);
	assign diff = $signed({1'b0, byte_in}) - $signed({1'b0, ffpcp_pkg::CHR_ZERO});
	assign wgt  = $signed({1'b0, ffpcp_pkg::digit_weight(pos_q)});
	assign prod = ffpcp_pkg::ACC_W'(diff * wgt);
	assign cmd  = ffpcp_pkg::letter_decode(letter_q);

	always_comb begin
		if (byte_in == ffpcp_pkg::CHR_PLUS) begin
			sign_new = ffpcp_pkg::SIGN_PLUS;
		end else if (byte_in == ffpcp_pkg::CHR_MINUS) begin
			sign_new = ffpcp_pkg::SIGN_MINUS;
		end else begin
			sign_new = ffpcp_pkg::SIGN_NONE;
		end
	end

	always_comb begin
		if (sign_q == ffpcp_pkg::SIGN_MINUS) begin
			sval = -{acc_q[ffpcp_pkg::ACC_W-1], acc_q};
		end else begin
			sval = {acc_q[ffpcp_pkg::ACC_W-1], acc_q};
		end
		if (sval < -ffpcp_pkg::VAL_LIMIT_WIDE) begin
			clamped = -ffpcp_pkg::VAL_LIMIT;
		end else if (sval >= ffpcp_pkg::VAL_LIMIT_WIDE) begin
			clamped = ffpcp_pkg::VAL_LIMIT;
		end else begin
			clamped = sval[ffpcp_pkg::VAL_W-1:0];
		end
	end

	assign hit = last && mk_q && (byte_in == ffpcp_pkg::CHR_END)
		&& (sign_q != ffpcp_pkg::SIGN_NONE) && (active_set <= ffpcp_pkg::SET_MAX)
		&& cmd.known;

	assign res.set    = active_set[ffpcp_pkg::SET_W-1:0];
	assign res.code   = cmd.code;
	assign res.set_id = (cmd.code == ffpcp_pkg::FIELD_SET_ID);
	assign res.value  = clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			acc_q    <= '0;
			sign_q   <= ffpcp_pkg::SIGN_NONE;
			letter_q <= '0;
			mk_q     <= 1'b0;
		end else if (fire) begin
			if (last) begin
				pos_q    <= '0;
				acc_q    <= '0;
				sign_q   <= ffpcp_pkg::SIGN_NONE;
				letter_q <= '0;
				mk_q     <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				case (pos_q)
					ffpcp_pkg::POS_START: mk_q     <= (byte_in == ffpcp_pkg::CHR_START);
					ffpcp_pkg::POS_CMD:   letter_q <= byte_in;
					ffpcp_pkg::POS_SIGN:  sign_q   <= sign_new;
					ffpcp_pkg::POS_DOT:   mk_q     <= mk_q && (byte_in == ffpcp_pkg::CHR_DOT);
					default:              acc_q    <= acc_q + prod;
				endcase
			end
		end
	end

endmodule

// ===== sv/fixed_frame_parameter_command_parser_top.sv =====
// Top level of the fixed-frame parameter command parser.
// Depends on ffpcp_pkg and ffpcp_frame.
`timescale 1ns / 1ps

// Usage
// Input channel: rx_byte with in_valid / in_stall; one frame byte per transfer.
// Frames are 13 consecutive bytes: S, letter, sign, 4 digits, '.', 4 digits, E.
// Framing is a plain byte count; there is no resynchronization.
// Config: cfg_we / cfg_wdata write active_set; write only while idle.
// Output channel: target_set, field_code, value_fixed with out_valid / out_stall;
// at most one result per frame, none for bad markers, sign, letter or set.
// Throughput: one byte per cycle while in_stall is low. Path: a result of a frame
// passes the input register, clamp register, reciprocal-multiply register and
// output register.
// Stall: the output register holds while out_valid and out_stall are high; results
// already computed collect in the two middle stages, and in_stall rises only when
// the closing byte of a frame cannot move on. Bytes that make no result never wait.
// Reset: arst_n clears the frame count and all valid flags; active_set reads 0.
module fixed_frame_parameter_command_parser_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ffpcp_pkg::BYTE_W-1:0]         cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ffpcp_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ffpcp_pkg::SET_W-1:0]          target_set,
	output logic [ffpcp_pkg::CODE_W-1:0]         field_code,
	output logic signed [ffpcp_pkg::VAL_W-1:0]   value_fixed
);

	logic [ffpcp_pkg::BYTE_W-1:0] active_set_q;

	logic                          v_s1;
	logic [ffpcp_pkg::BYTE_W-1:0]  b_s1;
	logic                          v_s2;
	ffpcp_pkg::result_t            r_s2;
	logic                          v_s3;
	ffpcp_pkg::result_t            r_s3;
	logic                          neg_s3;
	logic [ffpcp_pkg::QUOT_W-1:0]  q_s3;
	logic                          out_valid_q;
	logic [ffpcp_pkg::SET_W-1:0]   set_q;
	logic [ffpcp_pkg::CODE_W-1:0]  code_q;
	logic signed [ffpcp_pkg::VAL_W-1:0] value_q;

	logic                          hit;
	ffpcp_pkg::result_t            res;
	logic                          rdy_out;
	logic                          rdy3;
	logic                          rdy2;
	logic                          fire_s1;
	logic                          accept;
	logic [ffpcp_pkg::MAG_W-1:0]   mag;
	logic [ffpcp_pkg::DIV_W+ffpcp_pkg::RECIP_W-1:0] recip_prod;
	logic [ffpcp_pkg::MAG_W-1:0]   scaled;
	logic signed [ffpcp_pkg::VAL_W-1:0] value_next;

	ffpcp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.byte_in    (b_s1),
		.active_set (active_set_q),
		.hit        (hit),
		.res        (res)
	);

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign fire_s1  = v_s1 && (!hit || rdy2);
	assign in_stall = v_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	assign mag = r_s2.value[ffpcp_pkg::VAL_W-1] ? ffpcp_pkg::MAG_W'(-r_s2.value)
		: ffpcp_pkg::MAG_W'(r_s2.value);
	assign recip_prod = mag[ffpcp_pkg::MAG_W-1:ffpcp_pkg::DIV_SHIFT] * ffpcp_pkg::RECIP;
	assign scaled = ffpcp_pkg::MAG_W'(q_s3 * ffpcp_pkg::UNIT_ONE);

	always_comb begin
		if (!r_s3.set_id) begin
			value_next = r_s3.value;
		end else if (neg_s3) begin
			value_next = -$signed({1'b0, scaled});
		end else begin
			value_next = $signed({1'b0, scaled});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_set_q <= '0;
		end else if (cfg_we) begin
			active_set_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (rdy2) begin
				v_s2 <= fire_s1 && hit;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_s1 <= rx_byte;
		end
		if (rdy2) begin
			r_s2 <= res;
		end
		if (rdy3) begin
			r_s3   <= r_s2;
			neg_s3 <= r_s2.value[ffpcp_pkg::VAL_W-1];
			q_s3   <= recip_prod[ffpcp_pkg::RECIP_SHIFT+ffpcp_pkg::QUOT_W-1:ffpcp_pkg::RECIP_SHIFT];
		end
		if (rdy_out) begin
			set_q   <= r_s3.set;
			code_q  <= r_s3.code;
			value_q <= value_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign target_set  = set_q;
	assign field_code  = code_q;
	assign value_fixed = value_q;

endmodule

// ===== sv/ffpcp_checker.sv =====
// Port-level checker for the command parser, bound to the top level.
// Depends on ffpcp_pkg and the macros header.
`timescale 1ns / 1ps
`include "fixed_frame_parameter_command_parser_top_macros.svh"

module ffpcp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [ffpcp_pkg::CODE_W-1:0]        field_code,
	input logic signed [ffpcp_pkg::VAL_W-1:0]  value_fixed
);

	`FFPCP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(value_fixed) && $stable(field_code))
	`FFPCP_ASSERT_IMP(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall)
	`FFPCP_ASSERT_IMP(a_code_ok, clk, arst_n, out_valid, field_code <= 3'(ffpcp_pkg::FIELD_SET_ID))
	`FFPCP_ASSERT_IMP(a_value_rng, clk, arst_n, out_valid, (value_fixed <= ffpcp_pkg::VAL_LIMIT) && (value_fixed >= -ffpcp_pkg::VAL_LIMIT))

endmodule

bind fixed_frame_parameter_command_parser_top ffpcp_checker u_ffpcp_checker (.*);

// ===== tb/sv/ffpcp_write_checker.sv =====
// Checker for the fixed-frame parameter command parser: tracks the frame state from
// accepted bytes and configuration writes, and compares every result transfer in order.
// Depends on ffpcp_pkg for widths, characters and the field and sign enums.
`timescale 1ns / 1ps

module ffpcp_write_checker
	import ffpcp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [BYTE_W-1:0]         cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [BYTE_W-1:0]         rx_byte,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [SET_W-1:0]          target_set,
	input  logic [CODE_W-1:0]         field_code,
	input  logic signed [VAL_W-1:0]   value_fixed,
	output int                        pending_writes,
	output int                        mismatches
);

	localparam longint FULL_SCALE = 64'sd10000000;
	localparam longint ONE_UNIT   = 64'sd10000;

	typedef struct packed {
		logic [SET_W-1:0]        dest_set;
		field_t                  code;
		logic signed [VAL_W-1:0] value;
	} param_write_t;

	param_write_t        expected_writes[$];
	param_write_t        head;
	logic [BYTE_W-1:0]   cur_set;
	logic [POS_W-1:0]    frame_pos;
	longint              digit_sum;
	sign_t               frame_sign;
	logic [BYTE_W-1:0]   cmd_letter;
	logic                framing_ok;
	int                  err_count;

	task automatic clear_frame();
		frame_pos  = '0;
		digit_sum  = 0;
		frame_sign = SIGN_NONE;
		cmd_letter = '0;
		framing_ok = 1'b0;
	endtask

	task automatic take_byte(input logic [BYTE_W-1:0] b);
		logic [POS_W-1:0] p;
		longint           scale;
		longint           v;
		logic             known;
		logic             ok;
		field_t           code;
		int               expo;
		p = frame_pos;
		if (p > POS_LAST)
			p = POS_START;
		if (p != POS_LAST) begin
			case (p)
				POS_START: framing_ok = (b == CHR_START);
				POS_CMD:   cmd_letter = b;
				POS_SIGN: begin
					if (b == CHR_PLUS)
						frame_sign = SIGN_PLUS;
					else if (b == CHR_MINUS)
						frame_sign = SIGN_MINUS;
					else
						frame_sign = SIGN_NONE;
				end
				POS_DOT:   framing_ok = framing_ok && (b == CHR_DOT);
				default: begin
					expo  = (p < POS_DOT) ? 10 - int'(p) : 11 - int'(p);
					scale = 1;
					for (int k = 0; k < expo; k++)
						scale = scale * 10;
					digit_sum += (longint'(b) - longint'(CHR_ZERO)) * scale;
				end
			endcase
			frame_pos = p + 1'b1;
		end else begin
			ok = framing_ok && (b == CHR_END) && (frame_sign != SIGN_NONE)
				&& (cur_set <= SET_MAX);
			known = 1'b1;
			code  = FIELD_KP;
			case (cmd_letter)
				CHR_KP:    code = FIELD_KP;
				CHR_KI:    code = FIELD_KI;
				CHR_KD:    code = FIELD_KD;
				CHR_SETPT: code = FIELD_SETPT;
				CHR_LED:   code = FIELD_LED;
				CHR_SETID: code = FIELD_SET_ID;
				default:   known = 1'b0;
			endcase
			v = (frame_sign == SIGN_MINUS) ? -digit_sum : digit_sum;
			if (v < -FULL_SCALE)
				v = -FULL_SCALE;
			if (v >= FULL_SCALE)
				v = FULL_SCALE;
			clear_frame();
			if (ok && known) begin
				if (code == FIELD_SET_ID)
					v = (v / ONE_UNIT) * ONE_UNIT;
				expected_writes.push_back('{cur_set[SET_W-1:0], code, v[VAL_W-1:0]});
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_set = '0;
			clear_frame();
			expected_writes.delete();
			err_count = 0;
			pending_writes <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we)
				cur_set = cfg_wdata;
			if (in_valid && !in_stall)
				take_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (expected_writes.size() == 0) begin
					$error("unexpected write: target_set %0d field_code %0d value_fixed %0d",
						target_set, field_code, value_fixed);
					err_count++;
				end else begin
					head = expected_writes.pop_front();
					if (target_set !== head.dest_set) begin
						$error("target_set: expected %0d, actual %0d", head.dest_set, target_set);
						err_count++;
					end
					if (field_code !== head.code) begin
						$error("field_code: expected %0d, actual %0d", head.code, field_code);
						err_count++;
					end
					if (value_fixed !== head.value) begin
						$error("value_fixed: expected %0d, actual %0d", head.value, value_fixed);
						err_count++;
					end
				end
			end
			pending_writes <= expected_writes.size();
			mismatches <= err_count;
		end
	end

endmodule

// ===== tb/sv/fixed_frame_parameter_command_parser_top_tb.sv =====
// Testbench top for the fixed-frame parameter command parser: directed and random frames
// over several parameter-set settings, with random stalls on both sides and a long output hold.
// Depends on ffpcp_pkg, the parser top level and ffpcp_write_checker.
`timescale 1ns / 1ps

module fixed_frame_parameter_command_parser_top_tb;
	import ffpcp_pkg::*;

	localparam int STUCK_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 8;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [BYTE_W-1:0]         cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [BYTE_W-1:0]         rx_byte = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [SET_W-1:0]          target_set;
	logic [CODE_W-1:0]         field_code;
	logic signed [VAL_W-1:0]   value_fixed;
	int                        pending_writes;
	int                        mismatches;

	logic              send_gaps = 1'b1;
	logic              recv_gaps = 1'b1;
	logic              hold_req = 1'b0;
	int                hold_left = 0;
	int                stuck_cycles = 0;
	logic [BYTE_W-1:0] frame_buf [13];
	logic [BYTE_W-1:0] known_letters [6] = '{CHR_KP, CHR_KI, CHR_KD, CHR_SETPT, CHR_LED,
		CHR_SETID};
	logic [BYTE_W-1:0] phase_set [7];

	fixed_frame_parameter_command_parser_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.target_set  (target_set),
		.field_code  (field_code),
		.value_fixed (value_fixed)
	);

	ffpcp_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_set     (target_set),
		.field_code     (field_code),
		.value_fixed    (value_fixed),
		.pending_writes (pending_writes),
		.mismatches     (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, or one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (recv_gaps) begin
				out_stall <= ($urandom_range(99) < 37);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("[fixed_frame_parameter_command_parser_top] ERROR");
		$finish;
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		while (send_gaps && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < 13; i++)
			push_byte(frame_buf[i]);
	endtask

	task automatic build_frame(input logic [BYTE_W-1:0] letter, input logic [BYTE_W-1:0] sgn,
		input int ip, input int fp);
		int scale;
		frame_buf[0]  = CHR_START;
		frame_buf[1]  = letter;
		frame_buf[2]  = sgn;
		frame_buf[7]  = CHR_DOT;
		frame_buf[12] = CHR_END;
		scale = 1000;
		for (int i = 0; i < 4; i++) begin
			frame_buf[3 + i] = CHR_ZERO + 8'((ip / scale) % 10);
			frame_buf[8 + i] = CHR_ZERO + 8'((fp / scale) % 10);
			scale = scale / 10;
		end
	endtask

	// hold the input idle until the pipeline has drained, then write the set
	task automatic write_set(input logic [BYTE_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_writes == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_frame();
		int kind;
		int k;
		int ip;
		logic [BYTE_W-1:0] letter;
		logic [BYTE_W-1:0] sgn;
		kind = $urandom_range(99);
		letter = ($urandom_range(99) < 8) ? 8'($urandom) : known_letters[$urandom_range(5)];
		k = $urandom_range(99);
		sgn = (k < 45) ? CHR_PLUS : ((k < 90) ? CHR_MINUS : 8'($urandom));
		k = $urandom_range(99);
		if (k < 50)
			ip = $urandom_range(999);
		else if (k < 58)
			ip = 1000;
		else if (k < 75)
			ip = 1000 + $urandom_range(999);
		else
			ip = $urandom_range(9999);
		build_frame(letter, sgn, ip, $urandom_range(9999));
		if (kind < 10) begin
			k = $urandom_range(7);
			frame_buf[(k < 4) ? 3 + k : 4 + k] = 8'($urandom);
		end else if (kind < 18) begin
			k = $urandom_range(2);
			frame_buf[(k == 0) ? 0 : ((k == 1) ? 7 : 12)] = 8'($urandom);
		end else if (kind < 26) begin
			for (int i = 0; i < 13; i++)
				frame_buf[i] = 8'($urandom);
		end
		if (kind >= 26 && kind < 29) begin
			// shift the framing, then restore it
			k = $urandom_range(1, 12);
			repeat (k) push_byte(8'($urandom));
			send_frame();
			repeat (13 - k) push_byte(8'($urandom));
		end else begin
			send_frame();
		end
	endtask

	initial begin
		phase_set[0] = 8'd7;
		phase_set[1] = 8'd3;
		phase_set[2] = 8'd8;
		phase_set[3] = 8'd255;
		phase_set[4] = 8'd5;
		phase_set[5] = 8'($urandom_range(7));
		phase_set[6] = 8'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_set(8'd0);

		build_frame(CHR_KP, CHR_PLUS, 0, 0);
		send_frame();
		build_frame(CHR_KI, CHR_MINUS, 9999, 9999);
		send_frame();
		build_frame(CHR_KD, CHR_PLUS, 9999, 9999);
		send_frame();
		build_frame(CHR_SETPT, CHR_PLUS, 1000, 0);
		send_frame();
		build_frame(CHR_SETPT, CHR_MINUS, 1000, 0);
		send_frame();
		build_frame(CHR_LED, CHR_PLUS, 999, 9999);
		send_frame();
		build_frame(CHR_SETID, CHR_MINUS, 123, 4567);
		send_frame();
		build_frame(CHR_SETID, CHR_PLUS, 7, 9999);
		send_frame();
		build_frame(CHR_KP, CHR_PLUS, 0, 0);
		frame_buf[3] = 8'h00;
		send_frame();
		build_frame(CHR_KD, CHR_MINUS, 0, 0);
		frame_buf[11] = 8'hFF;
		send_frame();
		build_frame(CHR_KI, CHR_PLUS, 5, 0);
		frame_buf[8] = 8'h2F;
		send_frame();
		build_frame(CHR_KP, CHR_PLUS, 12, 3400);
		frame_buf[0] = 8'h73;
		send_frame();
		build_frame(CHR_KP, CHR_PLUS, 12, 3400);
		frame_buf[7] = 8'h2C;
		send_frame();
		build_frame(CHR_KP, CHR_PLUS, 12, 3400);
		frame_buf[12] = 8'h65;
		send_frame();
		build_frame(CHR_KP, 8'h20, 12, 3400);
		send_frame();
		build_frame(8'h50, CHR_PLUS, 1, 0);
		send_frame();

		for (int ph = 0; ph < 7; ph++) begin
			write_set(phase_set[ph]);
			send_gaps = (ph != 0 && ph != 4);
			recv_gaps = (ph != 4);
			if (ph == 0)
				hold_req = 1'b1;
			for (int f = 0; f < 16; f++) begin
				if (ph == 1 && f == 8) begin
					in_valid <= 1'b0;
					@(posedge clk);
					wait (pending_writes == 0);
				end
				random_frame();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_writes == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[fixed_frame_parameter_command_parser_top] OK");
		else
			$display("[fixed_frame_parameter_command_parser_top] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ffpcp_pkg.sv
sv/ffpcp_frame.sv
sv/fixed_frame_parameter_command_parser_top.sv
sv/ffpcp_checker.sv
tb/sv/ffpcp_write_checker.sv
tb/sv/fixed_frame_parameter_command_parser_top_tb.sv
